// ----- design/two_link_arm_pd_sim_step_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the two-link arm tick core
// Clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TWO_LINK_ARM_PD_SIM_STEP_CORE_MACROS_SVH
`define TWO_LINK_ARM_PD_SIM_STEP_CORE_MACROS_SVH

// same-cycle implication
`define TLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tlarm_pkg.sv -----
// ---------------------------------------------------------------------------
// tlarm_pkg
// Shared types, constants and saturation helper for the two-link arm core.
// ---------------------------------------------------------------------------
package tlarm_pkg;

  localparam int STEP_FRAC = 16;
  localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
  localparam longint PI_Q30 = 64'sd3373259426;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_DERIV_GAIN = 3'd1,
    CFG_TIME_STEP  = 3'd2,
    CFG_INERTIA_A  = 3'd3,
    CFG_INERTIA_B  = 3'd4,
    CFG_COUPLING_C = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              load;
    logic              step_scale;
    logic signed [31:0] opa;
    logic signed [31:0] opb;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/two_link_arm_pd_sim_step_core.sv -----
// ---------------------------------------------------------------------------
// two_link_arm_pd_sim_step_core
// One PD-controlled two-link arm simulation tick per input item.
// ---------------------------------------------------------------------------
// Each accepted item (two reference angles) runs one tick: PD torques, arm
// inertia and Coriolis terms from a quarter-wave sine table, explicit 2x2
// solve, then semi-implicit Euler on both joints; the item returned carries
// the new angles, rates and this tick's torques. All values are signed fixed
// point with FRAC_BITS fraction bits, saturated to 32 bits. One tick is
// the accepting cycle, 23 passes through the single shared multiplier,
// a sine and cosine table lookup, two divisions by the determinant in the
// bit-serial divider and the load of the output register. in_tready is
// high only between ticks; a finished item waits in the output register
// without holding off the next input. Configuration writes are taken in
// any cycle (cfg_ready is always high) and must only happen while no tick
// is in flight.
`include "two_link_arm_pd_sim_step_core_macros.svh"

module two_link_arm_pd_sim_step_core #(
  parameter int FRAC_BITS          = 16,
  parameter int SINE_TABLE_ENTRIES = 1024   // power of two
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] ref_angle_one, [63:32] ref_angle_two
  input  logic [63:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] angle_one, [63:32] rate_one, [95:64] angle_two,
  // [127:96] rate_two, [159:128] torque_one, [191:160] torque_two
  output logic [191:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import tlarm_pkg::*;

  localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES);
  localparam int TAB_AW = IDX_W - 1;
  localparam int TAB_W  = FRAC_BITS + 1;
  localparam int QN     = SINE_TABLE_ENTRIES / 4;
  localparam logic [IDX_W-1:0] HALF_K = IDX_W'(SINE_TABLE_ENTRIES / 2);
  localparam logic [IDX_W-1:0] QTR_K  = IDX_W'(QN);
  localparam logic [IDX_W:0]   FULL_K = (IDX_W+1)'(SINE_TABLE_ENTRIES);
  localparam logic [32:0]      IDX_RND = 33'd1 << (31 - IDX_W);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_TRIG, S_DIV1, S_DIV2, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_KP1, OP_KD1, OP_KP2, OP_KD2, OP_IDX, OP_IC, OP_H, OP_HV2, OP_HS,
    OP_HV1, OP_X1, OP_CV1, OP_CV2, OP_DETA, OP_DETB, OP_N1A, OP_N1B,
    OP_N2A, OP_N2B, OP_V1, OP_V2, OP_P1, OP_P2
  } op_t;

  // sine of a/(4N) turns for a folded into the first quadrant, Q30 Taylor
  function automatic longint sine_entry(input longint a);
    longint x, x2, term, sum;
    x    = a * PI_Q30 / (2 * SINE_TABLE_ENTRIES);
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;   sum = sum - term;
    term = ((term * x2) >>> 30) / 20;  sum = sum + term;
    term = ((term * x2) >>> 30) / 42;  sum = sum - term;
    term = ((term * x2) >>> 30) / 72;  sum = sum + term;
    term = ((term * x2) >>> 30) / 110; sum = sum - term;
    term = ((term * x2) >>> 30) / 156; sum = sum + term;
    term = ((term * x2) >>> 30) / 210; sum = sum - term;
    term = ((term * x2) >>> 30) / 272; sum = sum + term;
    term = ((term * x2) >>> 30) / 342; sum = sum - term;
    term = ((term * x2) >>> 30) / 420; sum = sum + term;
    term = ((term * x2) >>> 30) / 506; sum = sum - term;
    if (sum < 0) sum = 0;
    return (sum + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  endfunction

  logic [TAB_W-1:0] quarter_tab [0:QN];
  for (genvar j = 0; j <= QN; j++) begin : g_tab
    assign quarter_tab[j] = TAB_W'(sine_entry(longint'(4 * j)));
  end

  // configuration
  logic [30:0] kp_r, kd_r, pa_r, pb_r, pc_r;
  logic [15:0] dt_r;

  // sequencer
  state_t state_r;
  op_t    op_r;
  logic [1:0] ph_r;

  // joint state and working registers
  logic signed [31:0] pos1_r, vel1_r, pos2_r, vel2_r;
  logic signed [31:0] e1_r, e2_r, nv1_r, nv2_r, vs_r, t1_r, t2_r;
  logic signed [31:0] sn_r, cs_r, ic_r, h_r, m11_r, m12_r;
  logic signed [31:0] hv2_r, hs_r, hv1_r, cv1_r, w1_r, w2_r, acc1_r, acc2_r;
  logic signed [63:0] det_r, num1_r, num2_r;
  logic [IDX_W-1:0]   idx_r;
  logic [TAB_W-1:0]   tab_rd_r;
  logic               neg_r;
  logic               div_start_r;
  logic               out_valid_r;
  logic [191:0]       out_data_r;

  mul_req_t mul_req;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic signed [63:0] prod;
  logic signed [31:0] fm;

  // table index from pos_two times 1/(2*pi)
  logic [31:0]      frac_w;
  logic [32:0]      idx_sum_w;
  logic [IDX_W-1:0] idx_w;

  assign frac_w    = prod[FRAC_BITS+31:FRAC_BITS];
  assign idx_sum_w = {1'b0, frac_w} + IDX_RND;
  assign idx_w     = idx_sum_w[31 -: IDX_W];

  // quadrant fold: first pass sine, second pass cosine (quarter turn on)
  logic [IDX_W-1:0] trig_k, k1_w, k2_w;
  logic [IDX_W:0]   kneg_w;
  logic             trig_neg;
  logic signed [31:0] tab_s32;

  always_comb begin
    trig_k   = (ph_r == 2'd0) ? idx_r : idx_r + QTR_K;
    trig_neg = trig_k > HALF_K;
    kneg_w   = FULL_K - {1'b0, trig_k};
    k1_w     = trig_neg ? kneg_w[IDX_W-1:0] : trig_k;
    k2_w     = (k1_w > QTR_K) ? HALF_K - k1_w : k1_w;
  end

  assign tab_s32 = $signed({{(32-TAB_W){1'b0}}, tab_rd_r});

  logic signed [31:0] m11_w, m12_w;
  assign m11_w = sat32($signed(66'(pa_r)) + $signed(66'(pb_r)) + (66'(ic_r) <<< 1));
  assign m12_w = sat32($signed(66'(pb_r)) + 66'(ic_r));

  // operand selection for the shared multiplier
  always_comb begin
    mul_req.load       = (state_r == S_MUL) && (ph_r == 2'd0);
    mul_req.step_scale = 1'b0;
    mul_req.opa        = '0;
    mul_req.opb        = '0;
    case (op_r)
      OP_KP1:  begin mul_req.opa = $signed({1'b0, kp_r}); mul_req.opb = e1_r;  end
      OP_KD1:  begin mul_req.opa = $signed({1'b0, kd_r}); mul_req.opb = nv1_r; end
      OP_KP2:  begin mul_req.opa = $signed({1'b0, kp_r}); mul_req.opb = e2_r;  end
      OP_KD2:  begin mul_req.opa = $signed({1'b0, kd_r}); mul_req.opb = nv2_r; end
      OP_IDX:  begin mul_req.opa = pos2_r; mul_req.opb = INV_TWO_PI_Q32; end
      OP_IC:   begin mul_req.opa = $signed({1'b0, pc_r}); mul_req.opb = cs_r; end
      OP_H:    begin mul_req.opa = $signed({1'b0, pc_r}); mul_req.opb = sn_r; end
      OP_HV2:  begin mul_req.opa = h_r;   mul_req.opb = vel2_r; end
      OP_HS:   begin mul_req.opa = h_r;   mul_req.opb = vs_r;   end
      OP_HV1:  begin mul_req.opa = h_r;   mul_req.opb = vel1_r; end
      OP_X1:   begin mul_req.opa = hv2_r; mul_req.opb = vel1_r; end
      OP_CV1:  begin mul_req.opa = hs_r;  mul_req.opb = vel2_r; end
      OP_CV2:  begin mul_req.opa = hv1_r; mul_req.opb = vel1_r; end
      OP_DETA: begin mul_req.opa = m11_r; mul_req.opb = $signed({1'b0, pb_r}); end
      OP_DETB: begin mul_req.opa = m12_r; mul_req.opb = m12_r; end
      OP_N1A:  begin mul_req.opa = $signed({1'b0, pb_r}); mul_req.opb = w1_r; end
      OP_N1B:  begin mul_req.opa = m12_r; mul_req.opb = w2_r; end
      OP_N2A:  begin mul_req.opa = m11_r; mul_req.opb = w2_r; end
      OP_N2B:  begin mul_req.opa = m12_r; mul_req.opb = w1_r; end
      OP_V1:   begin
        mul_req.opa = acc1_r; mul_req.opb = $signed({16'd0, dt_r}); mul_req.step_scale = 1'b1;
      end
      OP_V2:   begin
        mul_req.opa = acc2_r; mul_req.opb = $signed({16'd0, dt_r}); mul_req.step_scale = 1'b1;
      end
      OP_P1:   begin
        mul_req.opa = vel1_r; mul_req.opb = $signed({16'd0, dt_r}); mul_req.step_scale = 1'b1;
      end
      OP_P2:   begin
        mul_req.opa = vel2_r; mul_req.opb = $signed({16'd0, dt_r}); mul_req.step_scale = 1'b1;
      end
      default: ;
    endcase
  end

  assign div_req.start = div_start_r;
  assign div_req.num   = (state_r == S_DIV1) ? num1_r : num2_r;
  assign div_req.den   = det_r >>> FRAC_BITS;

  tlarm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod),
    .fm   (fm)
  );

  tlarm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_KP1;
      ph_r        <= 2'd0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      kp_r        <= 31'd1966080;
      kd_r        <= 31'd1966080;
      dt_r        <= 16'd655;
      pa_r        <= 31'd190054;
      pb_r        <= 31'd49807;
      pc_r        <= 31'd57016;
      pos1_r      <= '0;
      vel1_r      <= '0;
      pos2_r      <= '0;
      vel2_r      <= '0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PROP_GAIN:  kp_r <= cfg_data[30:0];
          CFG_DERIV_GAIN: kd_r <= cfg_data[30:0];
          CFG_TIME_STEP:  dt_r <= cfg_data[15:0];
          CFG_INERTIA_A:  pa_r <= cfg_data[30:0];
          CFG_INERTIA_B:  pb_r <= cfg_data[30:0];
          CFG_COUPLING_C: pc_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            e1_r    <= sat32(66'($signed(in_tdata[31:0])) - 66'(pos1_r));
            e2_r    <= sat32(66'($signed(in_tdata[63:32])) - 66'(pos2_r));
            nv1_r   <= sat32(-66'(vel1_r));
            nv2_r   <= sat32(-66'(vel2_r));
            vs_r    <= sat32(66'(vel1_r) + 66'(vel2_r));
            op_r    <= OP_KP1;
            ph_r    <= 2'd0;
            state_r <= S_MUL;
          end
        end

        S_MUL: begin
          ph_r <= ph_r + 2'd1;
          // w1 is ready long before the numerators need it
          if (ph_r == 2'd0 && op_r == OP_CV2) w1_r <= sat32(66'(t1_r) - 66'(cv1_r));
          if (ph_r == 2'd3) begin
            case (op_r)
              OP_KP1:  begin t1_r <= fm; op_r <= OP_KD1; end
              OP_KD1:  begin t1_r <= sat32(66'(t1_r) + 66'(fm)); op_r <= OP_KP2; end
              OP_KP2:  begin t2_r <= fm; op_r <= OP_KD2; end
              OP_KD2:  begin t2_r <= sat32(66'(t2_r) + 66'(fm)); op_r <= OP_IDX; end
              OP_IDX:  begin idx_r <= idx_w; state_r <= S_TRIG; end
              OP_IC:   begin ic_r <= fm; op_r <= OP_H; end
              OP_H:    begin
                h_r   <= fm;
                m11_r <= m11_w;
                m12_r <= m12_w;
                op_r  <= OP_HV2;
              end
              OP_HV2:  begin hv2_r <= fm; op_r <= OP_HS; end
              OP_HS:   begin hs_r <= fm; op_r <= OP_HV1; end
              OP_HV1:  begin hv1_r <= fm; op_r <= OP_X1; end
              OP_X1:   begin cv1_r <= fm; op_r <= OP_CV1; end
              OP_CV1:  begin cv1_r <= sat32(-(66'(cv1_r) + 66'(fm))); op_r <= OP_CV2; end
              OP_CV2:  begin w2_r <= sat32(66'(t2_r) - 66'(fm)); op_r <= OP_DETA; end
              OP_DETA: begin det_r <= prod; op_r <= OP_DETB; end
              OP_DETB: begin det_r <= det_r - prod; op_r <= OP_N1A; end
              OP_N1A:  begin num1_r <= prod; op_r <= OP_N1B; end
              OP_N1B:  begin num1_r <= num1_r - prod; op_r <= OP_N2A; end
              OP_N2A:  begin num2_r <= prod; op_r <= OP_N2B; end
              OP_N2B:  begin
                num2_r      <= num2_r - prod;
                div_start_r <= 1'b1;
                state_r     <= S_DIV1;
              end
              OP_V1:   begin vel1_r <= sat32(66'(vel1_r) + 66'(fm)); op_r <= OP_V2; end
              OP_V2:   begin vel2_r <= sat32(66'(vel2_r) + 66'(fm)); op_r <= OP_P1; end
              OP_P1:   begin pos1_r <= sat32(66'(pos1_r) + 66'(fm)); op_r <= OP_P2; end
              OP_P2:   begin pos2_r <= sat32(66'(pos2_r) + 66'(fm)); state_r <= S_OUT; end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_TRIG: begin
          // registered table read, sine then cosine
          tab_rd_r <= quarter_tab[k2_w[TAB_AW-1:0]];
          neg_r    <= trig_neg;
          ph_r     <= ph_r + 2'd1;
          if (ph_r == 2'd1) sn_r <= neg_r ? -tab_s32 : tab_s32;
          if (ph_r == 2'd2) begin
            cs_r    <= neg_r ? -tab_s32 : tab_s32;
            ph_r    <= 2'd0;
            op_r    <= OP_IC;
            state_r <= S_MUL;
          end
        end

        S_DIV1: begin
          if (div_rsp.done) begin
            acc1_r      <= div_rsp.quot;
            div_start_r <= 1'b1;
            state_r     <= S_DIV2;
          end
        end

        S_DIV2: begin
          if (div_rsp.done) begin
            acc2_r  <= div_rsp.quot;
            op_r    <= OP_V1;
            ph_r    <= 2'd0;
            state_r <= S_MUL;
          end
        end

        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {t2_r, t1_r, vel2_r, pos2_r, vel1_r, pos1_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  `TLA_ASSERT_NXT(a_accept_starts, in_tvalid && in_tready, state_r == S_MUL && op_r == OP_KP1, "item accepted but tick not started")
  `TLA_ASSERT_IMP(a_phase_idle, state_r == S_IDLE || state_r == S_OUT, ph_r == 2'd0, "phase counter not parked")
  `TLA_ASSERT_IMP(a_div_done_state, div_rsp.done, state_r == S_DIV1 || state_r == S_DIV2, "quotient arrived outside divide states")
  `TLA_ASSERT_NXT(a_out_load, state_r == S_OUT && (!out_valid_r || out_tready), out_valid_r && state_r == S_IDLE, "result item not loaded")

endmodule

// ----- design/tlarm_mul.sv -----
// ---------------------------------------------------------------------------
// tlarm_mul
// Shared 32x32 signed multiplier: registered operands, registered product,
// then a rounded (half up) and saturated fixed-point result registered from the product.
// ---------------------------------------------------------------------------
module tlarm_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  tlarm_pkg::mul_req_t req,
  output logic signed [63:0]  prod,
  output logic signed [31:0]  fm
);
  import tlarm_pkg::*;

  localparam logic signed [64:0] HALF_FRAC = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] HALF_STEP = 65'sd1 <<< (STEP_FRAC - 1);

  logic signed [31:0] a_r, b_r;
  logic               step_r, step2_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] fm_r;
  logic signed [63:0] prod_w;
  logic signed [64:0] rnd_frac, rnd_step;

  assign prod_w   = a_r * b_r;
  assign rnd_frac = (65'(prod_r) + HALF_FRAC) >>> FRAC_BITS;
  assign rnd_step = (65'(prod_r) + HALF_STEP) >>> STEP_FRAC;

  always_ff @(posedge clk) begin
    if (req.load) begin
      a_r    <= req.opa;
      b_r    <= req.opb;
      step_r <= req.step_scale;
    end
    prod_r  <= prod_w;
    step2_r <= step_r;
    fm_r    <= step2_r ? sat32(66'(rnd_step)) : sat32(66'(rnd_frac));
  end

  assign prod = prod_r;
  assign fm   = fm_r;

endmodule

// ----- design/tlarm_div.sv -----
// ---------------------------------------------------------------------------
// tlarm_div
// Radix-2 restoring divider on magnitudes, one quotient bit a cycle,
// truncating toward zero, result saturated to 32 bits.
// ---------------------------------------------------------------------------
`include "two_link_arm_pd_sim_step_core_macros.svh"

module tlarm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tlarm_pkg::div_req_t req,
  output tlarm_pkg::div_rsp_t rsp
);
  import tlarm_pkg::*;

  localparam int DIV_STEPS = 64;
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_r, fin_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      dvd_r, dsr_r, rem_r;
  logic             neg_r, zden_r, nneg_r, nzero_r;
  logic signed [31:0] quot_r;

  logic [64:0] trial_w, diff_w;
  logic        qbit_w;
  logic [63:0] num_mag, den_mag;
  logic signed [31:0] fin_w;

  assign num_mag = req.num[63] ? (~req.num + 64'd1) : req.num;
  assign den_mag = req.den[63] ? (~req.den + 64'd1) : req.den;
  assign trial_w = {rem_r, dvd_r[63]};
  assign diff_w  = trial_w - {1'b0, dsr_r};
  assign qbit_w  = !diff_w[64];

  always_comb begin
    if (zden_r) begin
      if (nzero_r) fin_w = 32'sd0;
      else if (nneg_r) fin_w = 32'sh80000000;
      else fin_w = 32'sh7fffffff;
    end else if (!neg_r) begin
      fin_w = (dvd_r[63:31] != 33'd0) ? 32'sh7fffffff : $signed(dvd_r[31:0]);
    end else begin
      // magnitude 2^31 still fits once negated
      if (dvd_r[63:32] != 32'd0 || (dvd_r[31] && dvd_r[30:0] != 31'd0)) begin
        fin_w = 32'sh80000000;
      end else begin
        fin_w = $signed(-dvd_r[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.start) begin
        neg_r   <= req.num[63] ^ req.den[63];
        zden_r  <= (req.den == 64'sd0);
        nneg_r  <= req.num[63];
        nzero_r <= (req.num == 64'sd0);
        dvd_r   <= num_mag;
        dsr_r   <= den_mag;
        rem_r   <= '0;
        cnt_r   <= '0;
        busy_r  <= (req.den != 64'sd0);
        fin_r   <= (req.den == 64'sd0);
      end else if (busy_r) begin
        rem_r <= qbit_w ? diff_w[63:0] : trial_w[63:0];
        dvd_r <= {dvd_r[62:0], qbit_w};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        quot_r <= fin_w;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  `TLA_ASSERT_NXT(a_done_pulse, done_r, !done_r, "divider done held for more than one cycle")
  `TLA_ASSERT_IMP(a_busy_fin_excl, busy_r, !fin_r, "divider finishing while still iterating")
  `TLA_ASSERT_NXT(a_zero_den_skip, req.start && req.den == 64'sd0, fin_r && !busy_r, "zero divisor not short-cut")

endmodule

// ----- tb/tb_two_link_arm_pd_sim_step_core.sv -----
// ---------------------------------------------------------------------------
// Testbench for two_link_arm_pd_sim_step_core
// Drives reference-angle items with random gaps, predicts every tick from an
// internal model of the PD law, arm dynamics and Euler step, and checks each
// returned item field by field across several register settings.
// ---------------------------------------------------------------------------
module tb_two_link_arm_pd_sim_step_core;
  import tlarm_pkg::*;

  localparam int FB  = 16;
  localparam int NTB = 1024;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    longint angle_one, rate_one, angle_two, rate_two, torque_one, torque_two;
  } tick_result_t;

  function automatic longint sat(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b, int s);
    return sat((a * b + (64'sd1 <<< (s - 1))) >>> s);
  endfunction

  // Taylor sine of a/(4N) turns, Q30 internally
  function automatic longint table_sine(longint a);
    bit neg;
    longint x, x2, term, acc, r;
    neg = 0;
    if (a > 2 * NTB) a -= 4 * NTB;
    if (a < 0) begin
      neg = 1;
      a = -a;
    end
    if (a > NTB) a = 2 * NTB - a;
    x = a * PI_Q30 / (2 * NTB);
    x2 = (x * x) >>> 30;
    term = x;
    acc = x;
    for (int i = 1; i <= 11; i++) begin
      term = ((term * x2) >>> 30) / longint'((2 * i) * (2 * i + 1));
      if (i & 1) acc -= term;
      else acc += term;
    end
    if (acc < 0) acc = 0;
    r = (acc + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    return neg ? -r : r;
  endfunction

  function automatic longint table_index(longint q);
    longint p;
    logic [63:0] up, frac, idx;
    p = q * 64'sd683565276;
    up = p;
    frac = (up >> FB) & 64'hFFFF_FFFF;
    idx = (frac * NTB + 64'h8000_0000) >> 32;
    if (idx >= NTB) idx -= NTB;
    return longint'(idx);
  endfunction

  function automatic longint div_sat(longint num, longint den);
    if (den == 0) return num > 0 ? SMAX : (num < 0 ? SMIN : 0);
    return sat(num / den);
  endfunction

  class arm_scoreboard;
    longint kp, kd, dt, pa, pb, pc;
    longint q1, v1, q2, v2;
    tick_result_t pending[$];
    int mismatches;

    function void reset_model();
      kp = 1966080; kd = 1966080; dt = 655;
      pa = 190054; pb = 49807; pc = 57016;
      q1 = 0; v1 = 0; q2 = 0; v2 = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        CFG_PROP_GAIN:  kp = val[30:0];
        CFG_DERIV_GAIN: kd = val[30:0];
        CFG_TIME_STEP:  dt = val[15:0];
        CFG_INERTIA_A:  pa = val[30:0];
        CFG_INERTIA_B:  pb = val[30:0];
        CFG_COUPLING_C: pc = val[30:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [63:0] d);
      longint r1, r2, t1, t2, sn, cs, ic, h, m11, m12, m22, vs, hv1, hv2, hs;
      longint cv1, cv2, w1, w2, det, detf, n1, n2, a1, a2, idx;
      tick_result_t e;
      r1 = longint'($signed(d[31:0]));
      r2 = longint'($signed(d[63:32]));
      t1 = sat(qmul(kp, sat(r1 - q1), FB) + qmul(kd, sat(-v1), FB));
      t2 = sat(qmul(kp, sat(r2 - q2), FB) + qmul(kd, sat(-v2), FB));
      idx = table_index(q2);
      sn = table_sine(4 * idx);
      cs = table_sine((4 * idx + NTB) % (4 * NTB));
      ic = qmul(pc, cs, FB);
      m11 = sat(pa + pb + 2 * ic);
      m12 = sat(pb + ic);
      m22 = pb;
      h = qmul(pc, sn, FB);
      vs = sat(v1 + v2);
      hv2 = qmul(h, v2, FB);
      hs = qmul(h, vs, FB);
      hv1 = qmul(h, v1, FB);
      cv1 = sat(-(qmul(hv2, v1, FB) + qmul(hs, v2, FB)));
      cv2 = qmul(hv1, v1, FB);
      w1 = sat(t1 - cv1);
      w2 = sat(t2 - cv2);
      det = m11 * m22 - m12 * m12;
      detf = det >>> FB;
      n1 = m22 * w1 - m12 * w2;
      n2 = m11 * w2 - m12 * w1;
      a1 = div_sat(n1, detf);
      a2 = div_sat(n2, detf);
      v1 = sat(v1 + qmul(a1, dt, STEP_FRAC));
      v2 = sat(v2 + qmul(a2, dt, STEP_FRAC));
      q1 = sat(q1 + qmul(v1, dt, STEP_FRAC));
      q2 = sat(q2 + qmul(v2, dt, STEP_FRAC));
      e.angle_one = q1; e.rate_one = v1; e.angle_two = q2; e.rate_two = v2;
      e.torque_one = t1; e.torque_two = t2;
      pending.push_back(e);
    endfunction

    function void report(string f, longint x, logic [31:0] a);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d got %0d", f, x, $signed(a));
    endfunction

    function void check_result(logic [191:0] d);
      tick_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] != e.angle_one[31:0]) report("angle_one", e.angle_one, d[31:0]);
      if (d[63:32] != e.rate_one[31:0]) report("rate_one", e.rate_one, d[63:32]);
      if (d[95:64] != e.angle_two[31:0]) report("angle_two", e.angle_two, d[95:64]);
      if (d[127:96] != e.rate_two[31:0]) report("rate_two", e.rate_two, d[127:96]);
      if (d[159:128] != e.torque_one[31:0])
        report("torque_one", e.torque_one, d[159:128]);
      if (d[191:160] != e.torque_two[31:0])
        report("torque_two", e.torque_two, d[191:160]);
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_valid, cfg_ready;
  logic [63:0] in_tdata;
  logic [191:0] out_tdata;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  arm_scoreboard sb;
  int idle_cycles;
  bit rx_random;

  two_link_arm_pd_sim_step_core dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // receiver: random stall before each item once rx_random is set
  initial begin
    int w;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      w = rx_random ? $urandom_range(0, 5) : 0;
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
    end
  end

  initial begin
    @(posedge clk iff idle_cycles >= WDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // valid stays up between back-to-back items; it drops before a gap
  task automatic send_item(logic [31:0] r1, logic [31:0] r2, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 5) : 0;
    cfg_valid <= 0;
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {r2, r1};
    @(posedge clk iff in_tready);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk iff sb.pending.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 13'h1fff) * 64 - 32'sd262144;
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      send_item(rand_angle(), rand_angle(), 1);
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.reset_model();
    rx_random = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = CFG_PROP_GAIN;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes at reset settings, back to back
    send_item(32'h0, 32'h0, 0);
    send_item(32'h7fff_ffff, 32'h8000_0000, 0);
    send_item(32'h8000_0000, 32'h7fff_ffff, 0);
    send_item(32'h0001_0000, 32'hffff_0000, 0);
    send_item(32'h0003_243f, 32'h0003_243f, 0);
    send_item(32'hffff_ffff, 32'h0000_0001, 0);
    send_item(32'h5555_5555, 32'haaaa_aaaa, 0);
    drain();
    // zero time step holds the state
    write_cfg(CFG_TIME_STEP, 32'h0);
    send_item(32'h0002_0000, 32'h0001_0000, 0);
    send_item(32'h8000_0000, 32'h7fff_ffff, 0);
    drain();
    // zero plant makes the matrix singular
    write_cfg(CFG_TIME_STEP, 32'hffff);
    write_cfg(CFG_INERTIA_A, 32'h0);
    write_cfg(CFG_INERTIA_B, 32'h0);
    write_cfg(CFG_COUPLING_C, 32'h0);
    send_item(32'h0001_0000, 32'hffff_0000, 0);
    send_item(32'h0, 32'h0, 0);
    send_item(32'h0, 32'h0, 0);
    drain();
    // out-of-range index is ignored
    write_cfg(cfg_reg_t'(3'd6), 32'hffff_ffff);
    write_cfg(cfg_reg_t'(3'd7), 32'h1234_5678);
    write_cfg(CFG_PROP_GAIN, 32'hffff_ffff);
    write_cfg(CFG_DERIV_GAIN, 32'hffff_ffff);
    write_cfg(CFG_INERTIA_A, 32'hffff_ffff);
    write_cfg(CFG_INERTIA_B, 32'hffff_ffff);
    write_cfg(CFG_COUPLING_C, 32'hffff_ffff);
    send_item(32'h7fff_ffff, 32'h8000_0000, 0);
    send_item(32'h1234_5678, 32'h8765_4321, 0);
    drain();

    rx_random = 1;
    // reset-like settings
    write_cfg(CFG_PROP_GAIN, 1966080);
    write_cfg(CFG_DERIV_GAIN, 1966080);
    write_cfg(CFG_TIME_STEP, 655);
    write_cfg(CFG_INERTIA_A, 190054);
    write_cfg(CFG_INERTIA_B, 49807);
    write_cfg(CFG_COUPLING_C, 57016);
    random_phase(400);
    // random settings, mostly moderate
    for (int p = 0; p < 5; p++) begin
      write_cfg(CFG_PROP_GAIN, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 23));
      write_cfg(CFG_DERIV_GAIN, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 23));
      write_cfg(CFG_TIME_STEP, $urandom_range(1, 65535));
      write_cfg(CFG_INERTIA_A, $urandom_range(0, 3) ? $urandom_range(1, 1 << 20) : $urandom());
      write_cfg(CFG_INERTIA_B, $urandom_range(0, 3) ? $urandom_range(1, 1 << 20) : $urandom());
      write_cfg(CFG_COUPLING_C, $urandom_range(0, 3) ? $urandom_range(0, 1 << 20) : $urandom());
      random_phase(140);
    end

    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
